>>> hw/rtl/drf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drf_pkg
// shared constants and codes of the recursive row filter
// ----------------------------------------------------------------------------
package drf_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int CNT_W     = COL_W + 1;
  localparam int PIX_AW    = COL_W + 1;

  localparam int COEF_W = 16;
  localparam int PIX_W  = 8;
  localparam int Y_W    = 32;
  localparam int OUT_W  = 24;
  localparam int IDX_W  = 3;

  // item opcodes
  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // register indexes
  localparam logic [IDX_W-1:0] REG_A0    = 3'd0;
  localparam logic [IDX_W-1:0] REG_A1    = 3'd1;
  localparam logic [IDX_W-1:0] REG_A2    = 3'd2;
  localparam logic [IDX_W-1:0] REG_A3    = 3'd3;
  localparam logic [IDX_W-1:0] REG_B1    = 3'd4;
  localparam logic [IDX_W-1:0] REG_B2    = 3'd5;
  localparam logic [IDX_W-1:0] REG_WIDTH = 3'd6;

  localparam logic [CNT_W-1:0] WIDTH_RESET = CNT_W'(MAX_WIDTH);

endpackage

>>> hw/rtl/drf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drf_if
// pixel item channel and result item channel
// ----------------------------------------------------------------------------
interface drf_in_if;
  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic [drf_pkg::PIX_W-1:0] pixel;

  modport source (output valid, output opcode, output pixel, input ready);
  modport sink   (input valid, input opcode, input pixel, output ready);
endinterface

interface drf_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [drf_pkg::OUT_W-1:0] filtered_value;
  logic [drf_pkg::COL_W-1:0]        column;
  logic                            last_of_row;

  modport source (output valid, output filtered_value, output column, output last_of_row,
                  input ready);
  modport sink   (input valid, input filtered_value, input column, input last_of_row,
                  output ready);
endinterface

>>> hw/rtl/deriche_recursive_row_filter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deriche_recursive_row_filter_core
// second-order recursive row filter, causal plus anticausal pass, Q16.8 out
// ----------------------------------------------------------------------------
// Pixels of a row are pushed one per item; the causal pass runs as they
// arrive and its values go to an on-chip store. The item that completes a row
// starts the anticausal pass, which walks the row from right to left and
// writes yp+ym for every column 2..W-3 into a result buffer; those results then
// leave one per later item (push or drain), in ascending column order. All
// arithmetic uses one shared 16x33 multiplier, four products per recursion
// step. A drain item passes S_IDLE and S_EMIT; a pushed pixel then S_POST,
// on columns 2..W-3 after the causal step S_MAC, S_CRND. Any item is held
// longer while its result waits for room in the output register. The pixel
// completing a row runs the anticausal pass: A_PRE, then A_RD, A_GET, S_MAC,
// A_RND, A_SUM per column; the multiplier and single pixel read port set it.
// The pixel memory holds two row banks so the next row fills one bank while
// results of the finished row still sit in the result buffer. No clearing
// pass is needed after reset.
module deriche_recursive_row_filter_core (
  input  logic                              clk,
  input  logic                              rst,
  drf_in_if.sink                            pix_in,
  drf_out_if.source                         res_out,
  input  logic                              cfg_we,
  input  logic [drf_pkg::IDX_W-1:0]         cfg_index,
  input  logic [drf_pkg::COEF_W-1:0]        cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_EMIT, S_MAC, S_CRND, S_POST, A_PRE, A_RD, A_GET, A_RND, A_SUM
  } state_t;

  localparam logic signed [49:0] Y_MAX = 50'sd2147483647;
  localparam logic signed [49:0] Y_MIN = -50'sd2147483648;
  localparam logic signed [32:0] R_MAX = 33'sd8388607;
  localparam logic signed [32:0] R_MIN = -33'sd8388608;

  // configuration registers
  logic signed [drf_pkg::COEF_W-1:0] coef_a0, coef_a1, coef_a2, coef_a3, coef_b1, coef_b2;
  logic [drf_pkg::CNT_W-1:0]         row_width;

  // control
  state_t                     state;
  logic [2:0]                 mstep;
  logic                       pass;          // 0 causal, 1 anticausal
  logic                       it_push;
  logic [drf_pkg::PIX_W-1:0]  it_pixel;
  logic                       emit_pend;
  logic [drf_pkg::CNT_W-1:0]  column_count;
  logic                       bank;
  logic                       prev_row_ready;
  logic [drf_pkg::CNT_W-1:0]  load_width;
  logic [drf_pkg::CNT_W-1:0]  emit_width;
  logic [drf_pkg::COL_W-1:0]  emit_col;
  logic [drf_pkg::COL_W-1:0]  jcol;
  logic                       a_first;

  // datapath
  logic signed [drf_pkg::Y_W-1:0] hist1, hist2, ym1, ym2, yr;
  logic [drf_pkg::PIX_W-1:0]      xprev, xa1, xa2;
  logic signed [49:0]             acc;
  logic signed [48:0]             prod;

  // output register
  logic                              out_valid;
  logic signed [drf_pkg::OUT_W-1:0]  out_value;
  logic [drf_pkg::COL_W-1:0]         out_column;
  logic                              out_last;

  // memories
  logic [drf_pkg::PIX_W-1:0]  pix_mem [2*drf_pkg::MAX_WIDTH];
  logic signed [drf_pkg::Y_W-1:0]   cs_mem  [drf_pkg::MAX_WIDTH];
  logic signed [drf_pkg::OUT_W-1:0] res_mem [drf_pkg::MAX_WIDTH];

  logic                         pix_we;
  logic [drf_pkg::PIX_AW-1:0]   pix_waddr, pix_raddr;
  logic [drf_pkg::PIX_W-1:0]    pix_wdata, pix_rdata;
  logic                         cs_we;
  logic [drf_pkg::COL_W-1:0]    cs_waddr, cs_raddr;
  logic signed [drf_pkg::Y_W-1:0] cs_wdata, cs_rdata;
  logic                         res_we;
  logic [drf_pkg::COL_W-1:0]    res_waddr, res_raddr;
  logic signed [drf_pkg::OUT_W-1:0] res_wdata, res_rdata;

  logic                         accept;
  logic [drf_pkg::CNT_W-1:0]    lw_now;
  logic                         causal_col;
  logic                         out_free;
  logic [drf_pkg::COL_W-1:0]    cur_col;

  logic signed [15:0]  mac_coef;
  logic signed [32:0]  mac_op;
  logic signed [49:0]  rnd_t, rnd_sh;
  logic signed [drf_pkg::Y_W-1:0] rnd_y;
  logic signed [32:0]  sum_w;
  logic signed [drf_pkg::OUT_W-1:0] sum_sat;

  assign pix_in.ready = (state == S_IDLE);
  assign accept       = pix_in.valid && pix_in.ready;
  assign out_free     = !out_valid || res_out.ready;
  assign cur_col      = column_count[drf_pkg::COL_W-1:0];

  assign res_out.valid          = out_valid;
  assign res_out.filtered_value = out_value;
  assign res_out.column         = out_column;
  assign res_out.last_of_row    = out_last;

  // width sampled at the first pixel of a row, clamped to 1..MAX_WIDTH
  always_comb begin
    if (column_count != '0) begin
      lw_now = load_width;
    end else if (row_width > drf_pkg::CNT_W'(drf_pkg::MAX_WIDTH)) begin
      lw_now = drf_pkg::CNT_W'(drf_pkg::MAX_WIDTH);
    end else if (row_width == '0) begin
      lw_now = drf_pkg::CNT_W'(1);
    end else begin
      lw_now = row_width;
    end
  end

  // causal step runs on columns 2..W-3
  assign causal_col = (column_count >= drf_pkg::CNT_W'(2)) &&
                      ((12'(column_count) + 12'd3) <= 12'(load_width));

  // multiplier operand select: pixel terms scaled by 256, then feedback terms
  always_comb begin
    unique case (mstep)
      3'd0: begin
        mac_coef = pass ? coef_a2 : coef_a0;
        mac_op   = {17'b0, (pass ? xa1 : it_pixel), 8'b0};
      end
      3'd1: begin
        mac_coef = pass ? coef_a3 : coef_a1;
        mac_op   = {17'b0, (pass ? xa2 : xprev), 8'b0};
      end
      3'd2: begin
        mac_coef = coef_b1;
        mac_op   = 33'(pass ? ym1 : hist1);
      end
      3'd3: begin
        mac_coef = coef_b2;
        mac_op   = 33'(pass ? ym2 : hist2);
      end
      default: begin
        mac_coef = '0;
        mac_op   = '0;
      end
    endcase
  end

  // round to Q.8 (floor of +2^13 over 2^14), saturate to 32 bits
  always_comb begin
    rnd_t  = acc + 50'sd8192;
    rnd_sh = rnd_t >>> 14;
    if (rnd_sh > Y_MAX) begin
      rnd_y = drf_pkg::Y_W'(Y_MAX);
    end else if (rnd_sh < Y_MIN) begin
      rnd_y = drf_pkg::Y_W'(Y_MIN);
    end else begin
      rnd_y = rnd_sh[drf_pkg::Y_W-1:0];
    end
  end

  // yp + ym, saturated to the 24-bit result
  always_comb begin
    sum_w = 33'(cs_rdata) + 33'(yr);
    if (sum_w > R_MAX) begin
      sum_sat = drf_pkg::OUT_W'(R_MAX);
    end else if (sum_w < R_MIN) begin
      sum_sat = drf_pkg::OUT_W'(R_MIN);
    end else begin
      sum_sat = sum_w[drf_pkg::OUT_W-1:0];
    end
  end

  // memory port control
  always_comb begin
    pix_we    = 1'b0;
    pix_waddr = {bank, cur_col};
    pix_wdata = pix_in.pixel;
    pix_raddr = {bank, cur_col - drf_pkg::COL_W'(1)};
    cs_we     = (state == S_CRND);
    cs_waddr  = cur_col;
    cs_wdata  = rnd_y;
    cs_raddr  = jcol;
    res_we    = (state == A_SUM);
    res_waddr = jcol;
    res_wdata = sum_sat;
    res_raddr = emit_col;
    if (accept && pix_in.opcode == drf_pkg::OP_PUSH) begin
      pix_we = 1'b1;
    end
    if (state == A_PRE) begin
      pix_raddr = {bank, drf_pkg::COL_W'(load_width - drf_pkg::CNT_W'(1))};
    end else if (state == A_RD) begin
      pix_raddr = {bank, jcol + drf_pkg::COL_W'(1)};
    end
  end

  always_ff @(posedge clk) begin
    if (pix_we) begin
      pix_mem[pix_waddr] <= pix_wdata;
    end
    pix_rdata <= pix_mem[pix_raddr];
  end

  always_ff @(posedge clk) begin
    if (cs_we) begin
      cs_mem[cs_waddr] <= cs_wdata;
    end
    if (state == A_RD) begin
      cs_rdata <= cs_mem[cs_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (res_we) begin
      res_mem[res_waddr] <= res_wdata;
    end
    if (accept) begin
      res_rdata <= res_mem[res_raddr];
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a0   <= '0;
      coef_a1   <= '0;
      coef_a2   <= '0;
      coef_a3   <= '0;
      coef_b1   <= '0;
      coef_b2   <= '0;
      row_width <= drf_pkg::WIDTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        drf_pkg::REG_A0:    coef_a0   <= cfg_data;
        drf_pkg::REG_A1:    coef_a1   <= cfg_data;
        drf_pkg::REG_A2:    coef_a2   <= cfg_data;
        drf_pkg::REG_A3:    coef_a3   <= cfg_data;
        drf_pkg::REG_B1:    coef_b1   <= cfg_data;
        drf_pkg::REG_B2:    coef_b2   <= cfg_data;
        drf_pkg::REG_WIDTH: row_width <= cfg_data[drf_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // shared multiplier, registered product
  always_ff @(posedge clk) begin
    prod <= mac_coef * mac_op;
  end

  // item sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      mstep          <= '0;
      pass           <= 1'b0;
      it_push        <= 1'b0;
      emit_pend      <= 1'b0;
      column_count   <= '0;
      bank           <= 1'b0;
      prev_row_ready <= 1'b0;
      load_width     <= '0;
      emit_width     <= '0;
      emit_col       <= '0;
      jcol           <= '0;
      a_first        <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      // the output register is reloaded below when a result is due
      if (out_valid && res_out.ready && !(state == S_EMIT && emit_pend)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            it_push   <= (pix_in.opcode == drf_pkg::OP_PUSH);
            it_pixel  <= pix_in.pixel;
            emit_pend <= prev_row_ready;
            if (pix_in.opcode == drf_pkg::OP_PUSH && column_count == '0) begin
              load_width <= lw_now;
              hist1      <= '0;
              hist2      <= '0;
            end
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          xprev <= pix_rdata;
          // a pending result waits for room in the output register
          if (!emit_pend || out_free) begin
            if (emit_pend) begin
              out_valid  <= 1'b1;
              out_value  <= res_rdata;
              out_column <= emit_col;
              out_last   <= (12'(emit_col) == 12'(emit_width) - 12'd3);
              emit_col   <= emit_col + drf_pkg::COL_W'(1);
              if ((12'(emit_col) + 12'd1) > (12'(emit_width) - 12'd3)) begin
                prev_row_ready <= 1'b0;
              end
            end
            if (!it_push) begin
              state <= S_IDLE;
            end else if (causal_col) begin
              pass  <= 1'b0;
              mstep <= '0;
              state <= S_MAC;
            end else begin
              state <= S_POST;
            end
          end
        end
        S_MAC: begin
          if (mstep == 3'd0) begin
            acc <= '0;
          end else if (mstep <= 3'd2) begin
            acc <= acc + 50'(prod);
          end else begin
            acc <= acc - 50'(prod);
          end
          if (mstep == 3'd4) begin
            state <= pass ? A_RND : S_CRND;
          end else begin
            mstep <= mstep + 3'd1;
          end
        end
        S_CRND: begin
          hist2 <= hist1;
          hist1 <= rnd_y;
          state <= S_POST;
        end
        S_POST: begin
          if ((column_count + drf_pkg::CNT_W'(1)) >= load_width) begin
            // row complete
            prev_row_ready <= 1'b0;
            if (load_width >= drf_pkg::CNT_W'(5)) begin
              jcol    <= drf_pkg::COL_W'(load_width - drf_pkg::CNT_W'(3));
              ym1     <= '0;
              ym2     <= '0;
              a_first <= 1'b1;
              state   <= A_PRE;
            end else begin
              column_count <= '0;
              bank         <= ~bank;
              state        <= S_IDLE;
            end
          end else begin
            column_count <= column_count + drf_pkg::CNT_W'(1);
            state        <= S_IDLE;
          end
        end
        A_PRE: begin
          state <= A_RD;
        end
        A_RD: begin
          // x[j+2] is the x[j+1] of the step before
          xa2   <= a_first ? pix_rdata : xa1;
          state <= A_GET;
        end
        A_GET: begin
          xa1     <= pix_rdata;
          a_first <= 1'b0;
          pass    <= 1'b1;
          mstep   <= '0;
          state   <= S_MAC;
        end
        A_RND: begin
          yr    <= rnd_y;
          ym2   <= ym1;
          ym1   <= rnd_y;
          state <= A_SUM;
        end
        A_SUM: begin
          if (jcol == drf_pkg::COL_W'(2)) begin
            emit_width     <= load_width;
            emit_col       <= drf_pkg::COL_W'(2);
            prev_row_ready <= 1'b1;
            column_count   <= '0;
            bank           <= ~bank;
            state          <= S_IDLE;
          end else begin
            jcol  <= jcol - drf_pkg::COL_W'(1);
            state <= A_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // pending results never run past column W-3, the last result column of their row
  a_emit_range: assert property (@(posedge clk) disable iff (rst)
    prev_row_ready |-> (12'(emit_col) <= 12'(emit_width) - 12'd3))
    else $error("emit column beyond row end");

  // a waiting result is not overwritten by the next one
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !res_out.ready) |=> (out_valid && $stable(out_column)))
    else $error("result register overwritten");

  // a row in progress stays below its sampled width
  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && column_count != '0) |-> (column_count < load_width))
    else $error("column count past row width");

endmodule
